FILE: sv/sbsc_pkg.sv
`timescale 1ns / 1ps
package sbsc_pkg;

	localparam int COORD_BITS    = 32;
	localparam int FRACTION_BITS = 16;
	localparam int FACES         = 6;
	localparam int AXES          = 3;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [FRACTION_BITS:0]       frac_t;

	localparam frac_t FRAC_ONE = frac_t'(1) << FRACTION_BITS;

	typedef struct packed {
		coord_t start_x;
		coord_t start_y;
		coord_t start_z;
		coord_t end_x;
		coord_t end_y;
		coord_t end_z;
		coord_t box_min_x;
		coord_t box_min_y;
		coord_t box_min_z;
		coord_t box_max_x;
		coord_t box_max_y;
		coord_t box_max_z;
	} item_t;

	typedef struct packed {
		frac_t hit_fraction;
		logic  starts_inside;
	} result_t;

	typedef struct packed {
		logic             miss;
		logic             start_out;
		logic [FACES-1:0] enter;
		logic [FACES-1:0] leave;
	} flags_t;

endpackage

FILE: sv/segment_box_slab_clip.sv
`timescale 1ns / 1ps
// Channel  Handshake     Payload
// item     start / busy  item_t: start, end, box min, box max (Q16.16)
// result   done strobe   result_t: hit_fraction (Q1.16), starts_inside
//
// One item enters every cycle; busy stays low.
// A restoring divider computes one quotient bit per stage
// for each of the six faces.
// arst_n clears the valid bits of every stage; data registers hold no reset.
// The receiver cannot stall: done is high for one cycle per item.
module segment_box_slab_clip (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  sbsc_pkg::item_t   item,
	output logic              done,
	output sbsc_pkg::result_t result
);
	import sbsc_pkg::*;

	localparam int DW  = COORD_BITS + 1;
	localparam int UW  = COORD_BITS + 1;
	localparam int FB  = FRACTION_BITS;
	localparam int LAT = FB + 3;

	typedef logic signed [DW-1:0] dist_t;
	typedef logic [UW-1:0]        mag_t;
	typedef logic [FB-1:0]        quo_t;

	coord_t s_c [AXES];
	coord_t e_c [AXES];
	coord_t lo_c [AXES];
	coord_t hi_c [AXES];

	dist_t d1_s1 [FACES];
	dist_t d2_s1 [FACES];
	logic  vld_s1;

	mag_t   rem_sd [FB+1][FACES];
	mag_t   den_sd [FB+1][FACES];
	quo_t   quo_sd [FB+1][FACES];
	flags_t flg_sd [FB+1];
	logic   vld_sd [FB+1];

	result_t res_q;
	logic    done_q;

	assign busy = 1'b0;

	assign s_c[0]  = item.start_x;
	assign s_c[1]  = item.start_y;
	assign s_c[2]  = item.start_z;
	assign e_c[0]  = item.end_x;
	assign e_c[1]  = item.end_y;
	assign e_c[2]  = item.end_z;
	assign lo_c[0] = item.box_min_x;
	assign lo_c[1] = item.box_min_y;
	assign lo_c[2] = item.box_min_z;
	assign hi_c[0] = item.box_max_x;
	assign hi_c[1] = item.box_max_y;
	assign hi_c[2] = item.box_max_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < AXES; a++) begin
			d1_s1[a]      <= dist_t'(lo_c[a]) - dist_t'(s_c[a]);
			d2_s1[a]      <= dist_t'(lo_c[a]) - dist_t'(e_c[a]);
			d1_s1[a+AXES] <= dist_t'(s_c[a]) - dist_t'(hi_c[a]);
			d2_s1[a+AXES] <= dist_t'(e_c[a]) - dist_t'(hi_c[a]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= FB; j++) begin
				vld_sd[j] <= 1'b0;
			end
		end else begin
			vld_sd[0] <= vld_s1;
			for (int j = 1; j <= FB; j++) begin
				vld_sd[j] <= vld_sd[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		logic signed [DW:0] d1w;
		logic signed [DW:0] d2w;
		logic               ent;
		logic               ign;
		flags_t             f;
		f = '0;
		for (int k = 0; k < FACES; k++) begin
			d1w = (DW+1)'(d1_s1[k]);
			d2w = (DW+1)'(d2_s1[k]);
			ign = (d1w <= 0) && (d2w <= 0);
			ent = !ign && (d1w > d2w);
			if (d1w > 0) begin
				f.start_out = 1'b1;
				if (d2w >= 0) begin
					f.miss = 1'b1;
				end
			end
			f.enter[k] = ent;
			f.leave[k] = !ign && !ent;
			rem_sd[0][k] <= ent ? UW'(d1w) : UW'(-d1w);
			den_sd[0][k] <= ent ? UW'(d1w - d2w) : UW'(d2w - d1w);
			quo_sd[0][k] <= '0;
		end
		flg_sd[0] <= f;
	end

	always_ff @(posedge clk) begin
		logic [UW:0] rw;
		for (int j = 1; j <= FB; j++) begin
			flg_sd[j] <= flg_sd[j-1];
			for (int k = 0; k < FACES; k++) begin
				rw = {rem_sd[j-1][k], 1'b0};
				den_sd[j][k] <= den_sd[j-1][k];
				if (rw >= {1'b0, den_sd[j-1][k]}) begin
					rem_sd[j][k] <= UW'(rw - {1'b0, den_sd[j-1][k]});
					quo_sd[j][k] <= {quo_sd[j-1][k][FB-2:0], 1'b1};
				end else begin
					rem_sd[j][k] <= UW'(rw);
					quo_sd[j][k] <= {quo_sd[j-1][k][FB-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_sd[FB];
		end
	end

	always_ff @(posedge clk) begin
		frac_t   ent_f;
		frac_t   lv_f;
		frac_t   q;
		logic    ent_v;
		flags_t  f;
		result_t r;
		f     = flg_sd[FB];
		ent_f = '0;
		lv_f  = FRAC_ONE;
		ent_v = 1'b0;
		for (int k = 0; k < FACES; k++) begin
			q = frac_t'(quo_sd[FB][k]);
			if (f.enter[k]) begin
				ent_v = 1'b1;
				if (q > ent_f) begin
					ent_f = q;
				end
			end
			if (f.leave[k] && (q < lv_f)) begin
				lv_f = q;
			end
		end
		r = '0;
		if (f.miss) begin
			r.hit_fraction = FRAC_ONE;
		end else if (!f.start_out) begin
			r.starts_inside = 1'b1;
		end else if (!ent_v) begin
			r.hit_fraction = '0;
		end else if (ent_f < lv_f) begin
			r.hit_fraction = ent_f;
		end else begin
			r.hit_fraction = FRAC_ONE;
		end
		res_q <= r;
	end

	assign done   = done_q;
	assign result = res_q;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("item lost in pipeline");
	a_inside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.starts_inside) |-> (result.hit_fraction == '0))
		else $error("inside start with nonzero fraction");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.hit_fraction <= FRAC_ONE))
		else $error("fraction above one");
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_sd[FB]))
		else $error("result without item");
`endif

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
module tb;
	import sbsc_pkg::*;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	logic    busy;
	item_t   item = '0;
	logic    done;
	result_t result;

	segment_box_slab_clip dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.item(item), .done(done), .result(result)
	);

	always #5 clk = ~clk;

	result_t pending_hits[$];
	int      errors = 0;
	longint  cycles = 0;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct {
		item_t   it;
		logic    known;
		result_t res;
	} row_t;

	function automatic longint frac_quot(longint num, longint den);
		longint r, q;
		r = num;
		q = 0;
		for (int i = 0; i < FRACTION_BITS; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 1;
			end
		end
		return q;
	endfunction

	function automatic result_t clip_segment(item_t it);
		longint s[3], e[3], lo[3], hi[3];
		longint d1, d2, f, enter, leave, one;
		logic   outside;
		int     a;
		result_t r;
		one = longint'(1) << FRACTION_BITS;
		enter = -1;
		leave = one;
		outside = 1'b0;
		s[0] = it.start_x; s[1] = it.start_y; s[2] = it.start_z;
		e[0] = it.end_x; e[1] = it.end_y; e[2] = it.end_z;
		lo[0] = it.box_min_x; lo[1] = it.box_min_y; lo[2] = it.box_min_z;
		hi[0] = it.box_max_x; hi[1] = it.box_max_y; hi[2] = it.box_max_z;
		for (int k = 0; k < FACES; k++) begin
			a = (k < AXES) ? k : k - AXES;
			if (k < AXES) begin
				d1 = lo[a] - s[a];
				d2 = lo[a] - e[a];
			end else begin
				d1 = s[a] - hi[a];
				d2 = e[a] - hi[a];
			end
			if (d1 > 0) outside = 1'b1;
			if (d1 > 0 && d2 >= 0) begin
				r.hit_fraction = FRAC_ONE;
				r.starts_inside = 1'b0;
				return r;
			end
			if (!(d1 <= 0 && d2 <= 0)) begin
				if (d1 > d2) begin
					f = frac_quot(d1, d1 - d2);
					if (f > enter) enter = f;
				end else begin
					f = frac_quot(-d1, d2 - d1);
					if (f > one) f = one;
					if (f < leave) leave = f;
				end
			end
		end
		if (!outside) begin
			r.hit_fraction = '0;
			r.starts_inside = 1'b1;
		end else begin
			r.hit_fraction = (enter < leave) ? frac_t'((enter > 0) ? enter : 0) : FRAC_ONE;
			r.starts_inside = 1'b0;
		end
		return r;
	endfunction

	function automatic coord_t rand_coord(int mode);
		case (mode)
			0: return coord_t'($urandom);
			1: return coord_t'($urandom_range(0, 4) == 0 ? 32'h8000_0000 :
				$urandom_range(0, 3) == 0 ? 32'h7fff_ffff : $urandom);
			default: return coord_t'(int'($urandom_range(0, 40 << 16)) - (20 << 16));
		endcase
	endfunction

	function automatic item_t rand_item();
		item_t it;
		int    mode;
		coord_t t;
		mode = $urandom_range(0, 9) < 6 ? 2 : $urandom_range(0, 1);
		it.start_x = rand_coord(mode); it.start_y = rand_coord(mode);
		it.start_z = rand_coord(mode); it.end_x = rand_coord(mode);
		it.end_y = rand_coord(mode); it.end_z = rand_coord(mode);
		it.box_min_x = rand_coord(mode); it.box_min_y = rand_coord(mode);
		it.box_min_z = rand_coord(mode); it.box_max_x = rand_coord(mode);
		it.box_max_y = rand_coord(mode); it.box_max_z = rand_coord(mode);
		if ($urandom_range(0, 9) != 0) begin
			if (it.box_min_x > it.box_max_x) begin
				t = it.box_min_x; it.box_min_x = it.box_max_x; it.box_max_x = t;
			end
			if (it.box_min_y > it.box_max_y) begin
				t = it.box_min_y; it.box_min_y = it.box_max_y; it.box_max_y = t;
			end
			if (it.box_min_z > it.box_max_z) begin
				t = it.box_min_z; it.box_min_z = it.box_max_z; it.box_max_z = t;
			end
		end
		return it;
	endfunction

	function automatic item_t mk(int sx, int sy, int sz, int ex, int ey, int ez,
		int lx, int ly, int lz, int hx, int hy, int hz);
		item_t it;
		it.start_x = sx; it.start_y = sy; it.start_z = sz;
		it.end_x = ex; it.end_y = ey; it.end_z = ez;
		it.box_min_x = lx; it.box_min_y = ly; it.box_min_z = lz;
		it.box_max_x = hx; it.box_max_y = hy; it.box_max_z = hz;
		return it;
	endfunction

	localparam int U = 1 << 16;
	localparam int MN = 32'h8000_0000;
	localparam int MX = 32'h7fff_ffff;
	row_t rows[$];

	task automatic send(item_t it, logic known, result_t res);
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_hits.push_back(known ? res : clip_segment(it));
	endtask

	task automatic idle_burst();
		start <= 1'b0;
		repeat ($urandom_range(1, 15)) @(posedge clk);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
		if (arst_n && done) begin
			if (pending_hits.size() == 0) begin
				$display("%0t: unexpected result %h", $time, result);
				errors <= errors + 1;
			end else begin
				if (result.hit_fraction !== pending_hits[0].hit_fraction ||
					result.starts_inside !== pending_hits[0].starts_inside) begin
					$display("%0t: expected %h actual %h", $time, pending_hits[0], result);
					errors <= errors + 1;
				end
				void'(pending_hits.pop_front());
			end
		end
	end

	initial begin
		result_t none, in_box;
		none.hit_fraction = FRAC_ONE; none.starts_inside = 1'b0;
		in_box.hit_fraction = '0; in_box.starts_inside = 1'b1;
		rows.push_back('{mk(0,0,0, U,U,U, -U,-U,-U, U,U,U), 1, in_box});
		rows.push_back('{mk(U,0,0, U,0,0, -U,-U,-U, U,U,U), 1, in_box});
		rows.push_back('{mk(5*U,0,0, 6*U,0,0, -U,-U,-U, U,U,U), 1, none});
		rows.push_back('{mk(-5*U,0,0, -2*U,0,0, -U,-U,-U, U,U,U), 1, none});
		rows.push_back('{mk(-2*U,0,0, -U,0,0, -U,-U,-U, U,U,U), 1, none});
		rows.push_back('{mk(-U,0,0, U,0,0, 0,-U,-U, U,U,U), 0, none});
		rows.push_back('{mk(-3*U,0,0, 3*U,0,0, -U,-U,-U, U,U,U), 0, none});
		rows.push_back('{mk(0,-3*U,0, 0,3*U,0, -U,-U,-U, U,U,U), 0, none});
		rows.push_back('{mk(0,0,-3*U, 0,0,3*U, -U,-U,-U, U,U,U), 0, none});
		rows.push_back('{mk(3*U,0,0, -3*U,0,0, -U,-U,-U, U,U,U), 0, none});
		rows.push_back('{mk(0,3*U,0, 0,-3*U,0, -U,-U,-U, U,U,U), 0, none});
		rows.push_back('{mk(0,0,3*U, 0,0,-3*U, -U,-U,-U, U,U,U), 0, none});
		rows.push_back('{mk(-3*U,-3*U,0, 3*U,-2*U,0, -U,-U,-U, U,U,U), 0, none});
		rows.push_back('{mk(-3*U,2*U,0, 3*U,-2*U,0, -U,-U,-U, U,U,U), 0, none});
		rows.push_back('{mk(0,0,0, 0,0,0, U,U,U, -U,-U,-U), 0, none});
		rows.push_back('{mk(MN,MN,MN, MX,MX,MX, MN,MN,MN, MX,MX,MX), 1, in_box});
		rows.push_back('{mk(MN,0,0, MX,0,0, -U,-U,-U, U,U,U), 0, none});
		rows.push_back('{mk(MX,0,0, MN,0,0, -U,-U,-U, U,U,U), 0, none});
		rows.push_back('{mk(MN,MN,MN, MX,MX,MX, MX,MX,MX, MN,MN,MN), 0, none});
		rows.push_back('{mk(MX,MX,MX, MX,MX,MX, MN,MN,MN, MN,MN,MN), 1, none});
		rows.push_back('{mk(-1,0,0, 1,0,0, 0,0,0, 0,0,0), 0, none});
		rows.push_back('{mk(-U,0,0, 2*U,0,0, 0,0,0, 0,0,0), 0, none});
		rows.push_back('{mk(-1,-1,-1, -1,-1,-1, 0,0,0, 0,0,0), 1, none});
		rows.push_back('{mk(-U,0,0, U,0,0, 0,0,0, U,U,U), 0, none});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) send(rows[i].it, rows[i].known, rows[i].res);
		start <= 1'b0;
		while (pending_hits.size() != 0) @(posedge clk);
		for (int n = 0; n < 2000; n++) begin
			if (n < 1700 && $urandom_range(0, 5) == 0) idle_burst();
			send(rand_item(), 1'b0, none);
		end
		start <= 1'b0;
		while (pending_hits.size() != 0) @(posedge clk);
		repeat (FRACTION_BITS + 10) @(posedge clk);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
